// ----- hw/rtl/direct_mapped_cache_lookup_defines.svh -----
`ifndef DIRECT_MAPPED_CACHE_LOOKUP_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define DMC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmc assertion failed");

// Next-cycle implication, checked on every clock outside reset.
`define DMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmc assertion failed");

`endif

// ----- hw/rtl/dmc_pkg.sv -----
`default_nettype none
package dmc_pkg;

  localparam int TAG_W  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 9;

  localparam logic [1:0] ST_COLD     = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_HIT      = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
  } line_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dmc_mod_unit.sv -----
`default_nettype none
module dmc_mod_unit #(
  parameter int DW = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [DW-1:0]          dividend,
  input  wire logic [dmc_pkg::CNT_W-1:0] divisor,
  output logic [dmc_pkg::CNT_W-1:0]   rem,
  output dmc_pkg::div_stat_t          stat
);
  import dmc_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic [CNT_W:0]  rem_r, rem_nxt;
  logic [CNT_W:0]  trial;

  // Restoring remainder, one dividend bit per cycle, MSB first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    trial    = {rem_r[CNT_W-1:0], quo_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
      end else begin
        rem_nxt = trial;
      end
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rem       = rem_r[CNT_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ----- hw/rtl/dmc_line_ram.sv -----
`default_nettype none
module dmc_line_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire dmc_pkg::line_t  wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output dmc_pkg::line_t       rd_data
);
  import dmc_pkg::*;

  line_t mem [DEPTH];
  line_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/direct_mapped_cache_lookup.sv -----
// Direct-mapped cache lookup.
// Input channel in_*: one item per request, in_tdata = address [15:0], mem_word [47:16].
// Output channel out_*: one item per request, out_tdata = line_index [7:0], data [39:8];
// out_tuser = status (cold miss, conflict miss, hit).
// cfg_wr_en / cfg_wr_data set the line count used as index divisor; write only when idle.
// Sequence: accept, then one remainder step per used address bit (16 by default),
// then one line-memory read, then the result is loaded into the output register.
// One item at a time: the input reopens in the cycle after the result is loaded, and
// the serial remainder unit and the read/modify/write of the line memory set the pace.
// Reset: the line memory is swept, one line per cycle, over all LINES lines, marking
// every line empty; in_tready stays low for that time. Config writes are taken.
// Stall: a finished result sits in the output register; a new item is accepted and
// processed meanwhile, and waits before its write-back until the register is free.
`default_nettype none
`include "direct_mapped_cache_lookup_defines.svh"
module direct_mapped_cache_lookup #(
  parameter int LINES     = 256,
  parameter int ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // address [15:0], mem_word [47:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // line_index [7:0], data [39:8]
  output logic [1:0]       out_tuser,  // status [1:0]
  input  wire logic        cfg_wr_en,
  input  wire logic [8:0]  cfg_wr_data // lines_in_use [8:0]
);
  import dmc_pkg::*;

  localparam int A_W   = (ADDR_BITS < TAG_W) ? ADDR_BITS : TAG_W;
  localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0]  lines_r;
  logic [CNT_W-1:0]  eff_lines;
  logic [A_W-1:0]    addr_r;
  logic [DATA_W-1:0] word_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [7:0]        out_idx_r;
  logic [DATA_W-1:0] out_data_r;

  logic              in_acc;
  logic              div_start;
  logic [CNT_W-1:0]  div_rem;
  div_stat_t         div_stat;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  line_t             wr_data;
  logic              rd_en;
  line_t             rd_data;

  logic              hit;
  logic              slot_free;
  logic              load;

  // Clamp the configured count to 1..LINES.
  always_comb begin
    if (lines_r == '0) begin
      eff_lines = CNT_W'(1);
    end else if (int'(lines_r) > LINES) begin
      eff_lines = CNT_W'(LINES);
    end else begin
      eff_lines = lines_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r <= CNT_W'(256);
    end else if (cfg_wr_en) begin
      lines_r <= cfg_wr_data;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign div_start = in_acc;

  dmc_mod_unit #(
    .DW(A_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_tdata[A_W-1:0]),
    .divisor  (eff_lines),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  // Issue the line read as soon as the index is known.
  assign rd_en = (state_r == S_DIV) && div_stat.done;

  assign hit       = rd_data.valid && (rd_data.tag == TAG_W'(addr_r));
  assign slot_free = !out_valid_r || out_tready;
  assign load      = (state_r == S_LOOK) && slot_free;

  // Write back a fill or replace; sweep lines empty after reset.
  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      wr_en        = load && !hit;
      wr_addr      = idx_r;
      wr_data.valid = 1'b1;
      wr_data.tag   = TAG_W'(addr_r);
      wr_data.data  = word_r;
    end
  end

  dmc_line_ram #(
    .DEPTH(LINES),
    .AW   (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (IDX_W'(div_rem)),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(LINES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold request fields, index, and the result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r <= in_tdata[A_W-1:0];
      word_r <= in_tdata[47:16];
    end
    if (rd_en) begin
      idx_r <= IDX_W'(div_rem);
    end
    if (load) begin
      out_idx_r <= 8'(idx_r);
      if (!rd_data.valid) begin
        out_status_r <= ST_COLD;
        out_data_r   <= word_r;
      end else if (!hit) begin
        out_status_r <= ST_CONFLICT;
        out_data_r   <= word_r;
      end else begin
        out_status_r <= ST_HIT;
        out_data_r   <= rd_data.data;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r, out_idx_r};
  assign out_tuser  = out_status_r;

  `DMC_ASSERT_IMPL(a_no_accept_in_clear, state_r == S_CLEAR, !in_tready)
  `DMC_ASSERT_IMPL(a_div_only_in_div, div_stat.busy || div_stat.done, state_r == S_DIV)
  `DMC_ASSERT_IMPL(a_hit_no_write, (state_r == S_LOOK) && hit, !wr_en)
  `DMC_ASSERT_IMPL(a_load_slot_free, load, !out_valid_r || out_tready)
  `DMC_ASSERT_NEXT(a_load_shows, load, out_tvalid)

endmodule
`default_nettype wire
